>>> hdl/bfha_pkg.sv
// shared types and constants of the best-fit heap allocator
`default_nettype none
package bfha_pkg;

    localparam int ADDR_W = 32;
    localparam int SIZE_W = 29;
    localparam int ST_W   = 3;
    localparam int CFG_W  = 2;

    localparam logic [ADDR_W-1:0] HEAP_START_RST  = 32'h0000_0000;
    localparam logic [SIZE_W-1:0] HEAP_LENGTH_RST = 29'd1048576;
    localparam logic [3:0]        ROUND_MASK      = 4'hF;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [ST_W-1:0] ST_NO_FIT    = 3'd2;
    localparam logic [ST_W-1:0] ST_UNKNOWN   = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_W-1:0] CFG_HEAP_START  = 2'd0;
    localparam logic [CFG_W-1:0] CFG_HEAP_LENGTH = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE, S_FSCAN, S_USCAN, S_PSCAN, S_JSCAN, S_JSHIFT, S_DONE
    } t_state;

    // table update broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD, OP_WRITE, OP_SHL, OP_SHR
    } t_op;

    // what the free-table scan wave looks for
    typedef enum logic [1:0] {
        SC_FIT, SC_PLACE, SC_JOIN
    } t_scan;

    typedef enum logic [1:0] {
        PL_FRONT, PL_BACK, PL_INSERT
    } t_place;

    typedef struct packed {
        logic              hit;
        t_place            kind;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              best_hit;
        logic [ADDR_W-1:0] best_start;
        logic [SIZE_W-1:0] best_size;
    } t_fcarry;

    typedef struct packed {
        logic              hit;
        logic [SIZE_W-1:0] size;
    } t_ucarry;

endpackage
`default_nettype wire

>>> hdl/bfha_free_cell.sv
// one free-table entry with its stage of the scan wave
`default_nettype none
module bfha_free_cell #(
    parameter int IW = 8,
    parameter int CW = 9
) (
    input  wire logic                     i_clk,
    input  wire logic [IW-1:0]            i_pos,
    input  wire logic [CW-1:0]            i_count,
    input  wire bfha_pkg::t_op            i_op,
    input  wire logic [IW-1:0]            i_idx,
    input  wire logic [bfha_pkg::ADDR_W-1:0] i_new_start,
    input  wire logic [bfha_pkg::SIZE_W-1:0] i_new_size,
    input  wire logic [bfha_pkg::ADDR_W-1:0] i_left_start,
    input  wire logic [bfha_pkg::SIZE_W-1:0] i_left_size,
    input  wire logic [bfha_pkg::ADDR_W-1:0] i_right_start,
    input  wire logic [bfha_pkg::SIZE_W-1:0] i_right_size,
    output logic [bfha_pkg::ADDR_W-1:0]      o_start,
    output logic [bfha_pkg::SIZE_W-1:0]      o_size,
    input  wire bfha_pkg::t_scan          i_mode,
    input  wire logic [bfha_pkg::SIZE_W-1:0] i_key_size,
    input  wire logic [bfha_pkg::ADDR_W-1:0] i_key_addr,
    input  wire logic [bfha_pkg::ADDR_W-1:0] i_key_end,
    input  wire bfha_pkg::t_fcarry        i_carry,
    input  wire logic [IW-1:0]            i_hidx,
    input  wire logic [IW-1:0]            i_bidx,
    output bfha_pkg::t_fcarry             o_carry,
    output logic [IW-1:0]                 o_hidx,
    output logic [IW-1:0]                 o_bidx
);
    import bfha_pkg::*;

    logic [ADDR_W-1:0] r_start, n_start;
    logic [SIZE_W-1:0] r_size, n_size;
    t_fcarry           r_carry, n_carry;
    logic [IW-1:0]     r_hidx, n_hidx, r_bidx, n_bidx;
    logic              w_valid;
    logic [ADDR_W-1:0] w_left_end;

    assign o_start = r_start;
    assign o_size  = r_size;
    assign o_carry = r_carry;
    assign o_hidx  = r_hidx;
    assign o_bidx  = r_bidx;

    // entry update
    always_comb begin
        n_start = r_start;
        n_size  = r_size;
        case (i_op)
            OP_WRITE: begin
                if (i_pos == i_idx) begin
                    n_start = i_new_start;
                    n_size  = i_new_size;
                end
            end
            OP_SHL: begin
                if (i_pos >= i_idx) begin
                    n_start = i_right_start;
                    n_size  = i_right_size;
                end
            end
            OP_SHR: begin
                if (i_pos == i_idx) begin
                    n_start = i_new_start;
                    n_size  = i_new_size;
                end else if (i_pos > i_idx) begin
                    n_start = i_left_start;
                    n_size  = i_left_size;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_valid    = CW'(i_pos) < i_count;
    assign w_left_end = i_left_start + ADDR_W'(i_left_size);

    // scan stage
    always_comb begin
        n_carry = i_carry;
        n_hidx  = i_hidx;
        n_bidx  = i_bidx;
        unique case (i_mode)
            SC_FIT: begin
                if (w_valid) begin
                    if (!i_carry.hit && r_size == i_key_size) begin
                        n_carry.hit   = 1'b1;
                        n_carry.start = r_start;
                        n_carry.size  = r_size;
                        n_hidx        = i_pos;
                    end
                    if (r_size > i_key_size &&
                        (!i_carry.best_hit || r_size < i_carry.best_size)) begin
                        n_carry.best_hit   = 1'b1;
                        n_carry.best_start = r_start;
                        n_carry.best_size  = r_size;
                        n_bidx             = i_pos;
                    end
                end
            end
            SC_PLACE: begin
                if (w_valid && !i_carry.hit) begin
                    if (i_key_end == r_start) begin
                        n_carry.hit   = 1'b1;
                        n_carry.kind  = PL_FRONT;
                        n_carry.start = r_start;
                        n_carry.size  = r_size;
                        n_hidx        = i_pos;
                    end else if (i_pos != '0 && w_left_end == i_key_addr) begin
                        n_carry.hit   = 1'b1;
                        n_carry.kind  = PL_BACK;
                        n_carry.start = i_left_start;
                        n_carry.size  = i_left_size;
                        n_hidx        = i_pos - 1'b1;
                    end else if (i_key_end < r_start) begin
                        n_carry.hit   = 1'b1;
                        n_carry.kind  = PL_INSERT;
                        n_hidx        = i_pos;
                    end
                end
            end
            SC_JOIN: begin
                if (w_valid && !i_carry.hit && i_pos != '0 && w_left_end == r_start) begin
                    n_carry.hit   = 1'b1;
                    n_carry.start = i_left_start;
                    n_carry.size  = i_left_size + r_size;
                    n_hidx        = i_pos - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_size  <= n_size;
        r_carry <= n_carry;
        r_hidx  <= n_hidx;
        r_bidx  <= n_bidx;
    end

endmodule
`default_nettype wire

>>> hdl/bfha_used_cell.sv
// one allocated-table entry with its stage of the lookup wave
`default_nettype none
module bfha_used_cell #(
    parameter int IW = 8,
    parameter int CW = 9
) (
    input  wire logic                     i_clk,
    input  wire logic [IW-1:0]            i_pos,
    input  wire logic [CW-1:0]            i_count,
    input  wire bfha_pkg::t_op            i_op,
    input  wire logic [IW-1:0]            i_idx,
    input  wire logic [bfha_pkg::ADDR_W-1:0] i_new_start,
    input  wire logic [bfha_pkg::SIZE_W-1:0] i_new_size,
    input  wire logic [bfha_pkg::ADDR_W-1:0] i_right_start,
    input  wire logic [bfha_pkg::SIZE_W-1:0] i_right_size,
    output logic [bfha_pkg::ADDR_W-1:0]      o_start,
    output logic [bfha_pkg::SIZE_W-1:0]      o_size,
    input  wire logic [bfha_pkg::ADDR_W-1:0] i_key_addr,
    input  wire bfha_pkg::t_ucarry        i_carry,
    input  wire logic [IW-1:0]            i_hidx,
    output bfha_pkg::t_ucarry             o_carry,
    output logic [IW-1:0]                 o_hidx
);
    import bfha_pkg::*;

    logic [ADDR_W-1:0] r_start, n_start;
    logic [SIZE_W-1:0] r_size, n_size;
    t_ucarry           r_carry, n_carry;
    logic [IW-1:0]     r_hidx, n_hidx;

    assign o_start = r_start;
    assign o_size  = r_size;
    assign o_carry = r_carry;
    assign o_hidx  = r_hidx;

    // entry update
    always_comb begin
        n_start = r_start;
        n_size  = r_size;
        case (i_op)
            OP_WRITE: begin
                if (i_pos == i_idx) begin
                    n_start = i_new_start;
                    n_size  = i_new_size;
                end
            end
            OP_SHL: begin
                if (i_pos >= i_idx) begin
                    n_start = i_right_start;
                    n_size  = i_right_size;
                end
            end
            default: begin
            end
        endcase
    end

    // first entry whose start matches the address
    always_comb begin
        n_carry = i_carry;
        n_hidx  = i_hidx;
        if (CW'(i_pos) < i_count && !i_carry.hit && r_start == i_key_addr) begin
            n_carry.hit  = 1'b1;
            n_carry.size = r_size;
            n_hidx       = i_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_size  <= n_size;
        r_carry <= n_carry;
        r_hidx  <= n_hidx;
    end

endmodule
`default_nettype wire

>>> hdl/best_fit_heap_allocator.sv
// Best-fit heap allocator with an address-sorted, coalescing free table and an
// allocated table, each held in a row of TABLE_ENTRIES cells. Every request is
// accepted in the idle state; one that passes the checks then runs one or more
// scan waves that ripple one cell per cycle down a table: an allocate uses one
// wave, a free uses up to three waves plus a shift. Errors found before a scan
// and frees of address zero skip the scans. Inserts and removals shift a whole
// table at once. A new request is taken while the last result still waits on
// the output. Config writes rebuild both tables at once and must only come
// while the block is idle.
`default_nettype none
module best_fit_heap_allocator #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // req_size[28:0], block_addr[60:29]
    input  wire logic        s_axis_tuser,   // cmd[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // granted_addr[31:0], block_bytes[60:32]
    output logic [2:0]       m_axis_tuser,   // status[2:0]
    input  wire logic        i_cfg_we,
    input  wire logic [bfha_pkg::CFG_W-1:0] i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata
);
    import bfha_pkg::*;

    localparam int N  = TABLE_ENTRIES;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);

    t_state r_state, n_state;

    logic [ADDR_W-1:0] r_heap_start, n_heap_start;
    logic [SIZE_W-1:0] r_heap_len, n_heap_len;
    logic [CW-1:0]     r_fcount, n_fcount, r_ucount, n_ucount, r_cnt, n_cnt;
    logic [SIZE_W-1:0] r_key_size, n_key_size;
    logic [ADDR_W-1:0] r_key_addr, n_key_addr, r_key_end, n_key_end;
    logic [SIZE_W-1:0] r_tsize, n_tsize;
    logic [IW-1:0]     r_uidx, n_uidx, r_jidx, n_jidx;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic [SIZE_W-1:0] r_res_bytes, n_res_bytes;
    logic [ST_W-1:0]   r_res_st, n_res_st;
    logic              r_mvalid, n_mvalid;
    logic [ADDR_W-1:0] r_mout_addr, n_mout_addr;
    logic [SIZE_W-1:0] r_mout_bytes, n_mout_bytes;
    logic [ST_W-1:0]   r_mout_st, n_mout_st;

    // table control
    t_op               w_fop, w_uop;
    logic [IW-1:0]     w_fidx, w_uidx;
    logic [ADDR_W-1:0] w_fnew_start, w_unew_start;
    logic [SIZE_W-1:0] w_fnew_size, w_unew_size;
    t_scan             w_mode;

    // cell row wiring
    logic [ADDR_W-1:0] w_fs [N];
    logic [SIZE_W-1:0] w_fz [N];
    logic [ADDR_W-1:0] w_us [N];
    logic [SIZE_W-1:0] w_uz [N];
    t_fcarry           w_fc [N];
    logic [IW-1:0]     w_fh [N];
    logic [IW-1:0]     w_fb [N];
    t_ucarry           w_uc [N];
    logic [IW-1:0]     w_uh [N];

    // request decode
    logic              w_accept, w_done, w_ffull, w_ufull;
    logic              w_cmd;
    logic [SIZE_W-1:0] w_req;
    logic [ADDR_W-1:0] w_addr;
    logic [SIZE_W:0]   w_rsize;
    logic              w_cfg_hit;
    t_fcarry           w_fl;
    t_ucarry           w_ul;
    logic [IW-1:0]     w_fl_h, w_fl_b, w_ul_h;

    assign w_cmd    = s_axis_tuser;
    assign w_req    = s_axis_tdata[SIZE_W-1:0];
    assign w_addr   = s_axis_tdata[SIZE_W+ADDR_W-1:SIZE_W];
    assign w_rsize  = ({1'b0, w_req} + (SIZE_W+1)'(ROUND_MASK)) & ~(SIZE_W+1)'(ROUND_MASK);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_done   = r_cnt == CW'(N);
    assign w_ffull  = r_fcount == CW'(N);
    assign w_ufull  = r_ucount == CW'(N);
    assign w_cfg_hit = i_cfg_we && (i_cfg_addr == CFG_HEAP_START ||
                                    i_cfg_addr == CFG_HEAP_LENGTH);
    assign w_fl     = w_fc[N-1];
    assign w_fl_h   = w_fh[N-1];
    assign w_fl_b   = w_fb[N-1];
    assign w_ul     = w_uc[N-1];
    assign w_ul_h   = w_uh[N-1];

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {3'b000, r_mout_bytes, r_mout_addr};
    assign m_axis_tuser  = r_mout_st;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_cmd == CMD_ALLOC) begin
                        if (w_req == '0 || w_ufull || w_rsize[SIZE_W]) n_state = S_DONE;
                        else n_state = S_FSCAN;
                    end else begin
                        n_state = (w_addr == '0) ? S_DONE : S_USCAN;
                    end
                end
            end
            S_FSCAN: if (w_done) n_state = S_DONE;
            S_USCAN: if (w_done) n_state = w_ul.hit ? S_PSCAN : S_DONE;
            S_PSCAN: begin
                if (w_done) begin
                    if (w_fl.hit && w_fl.kind != PL_INSERT) n_state = S_JSCAN;
                    else if (w_fl.hit || w_ffull) n_state = S_DONE;
                    else n_state = S_JSCAN;
                end
            end
            S_JSCAN: if (w_done) n_state = w_fl.hit ? S_JSHIFT : S_DONE;
            S_JSHIFT: n_state = S_DONE;
            S_DONE: if (!r_mvalid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and table control
    always_comb begin
        n_heap_start = r_heap_start;
        n_heap_len   = r_heap_len;
        n_fcount     = r_fcount;
        n_ucount     = r_ucount;
        n_cnt        = (n_state != r_state) ? '0 : r_cnt + 1'b1;
        n_key_size   = r_key_size;
        n_key_addr   = r_key_addr;
        n_key_end    = r_key_end;
        n_tsize      = r_tsize;
        n_uidx       = r_uidx;
        n_jidx       = r_jidx;
        n_res_addr   = r_res_addr;
        n_res_bytes  = r_res_bytes;
        n_res_st     = r_res_st;
        n_mvalid     = r_mvalid && !m_axis_tready;
        n_mout_addr  = r_mout_addr;
        n_mout_bytes = r_mout_bytes;
        n_mout_st    = r_mout_st;
        w_fop        = OP_HOLD;
        w_fidx       = '0;
        w_fnew_start = r_key_addr;
        w_fnew_size  = r_tsize;
        w_uop        = OP_HOLD;
        w_uidx       = r_ucount[IW-1:0];
        w_unew_start = '0;
        w_unew_size  = r_key_size;
        w_mode       = SC_FIT;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_addr  = '0;
                    n_res_bytes = '0;
                    n_key_size  = w_rsize[SIZE_W-1:0];
                    n_key_addr  = w_addr;
                    if (w_cmd == CMD_ALLOC) begin
                        if (w_req == '0) n_res_st = ST_ZERO_SIZE;
                        else if (w_ufull) n_res_st = ST_FULL;
                        else if (w_rsize[SIZE_W]) n_res_st = ST_NO_FIT;
                        else n_res_st = ST_OK;
                    end else begin
                        n_res_st = ST_OK;
                    end
                end
            end
            S_FSCAN: begin
                w_mode = SC_FIT;
                if (w_done) begin
                    if (w_fl.hit || w_fl.best_hit) begin
                        // exact block goes away, otherwise the front of the best one
                        if (w_fl.hit) begin
                            w_fop        = OP_SHL;
                            w_fidx       = w_fl_h;
                            w_unew_start = w_fl.start;
                            n_fcount     = r_fcount - 1'b1;
                        end else begin
                            w_fop        = OP_WRITE;
                            w_fidx       = w_fl_b;
                            w_fnew_start = w_fl.best_start + ADDR_W'(r_key_size);
                            w_fnew_size  = w_fl.best_size - r_key_size;
                            w_unew_start = w_fl.best_start;
                        end
                        w_uop       = OP_WRITE;
                        n_ucount    = r_ucount + 1'b1;
                        n_res_addr  = w_unew_start;
                        n_res_bytes = r_key_size;
                        n_res_st    = ST_OK;
                    end else begin
                        n_res_st = ST_NO_FIT;
                    end
                end
            end
            S_USCAN: begin
                if (w_done) begin
                    if (w_ul.hit) begin
                        n_uidx    = w_ul_h;
                        n_tsize   = w_ul.size;
                        n_key_end = r_key_addr + ADDR_W'(w_ul.size);
                    end else begin
                        n_res_st = ST_UNKNOWN;
                    end
                end
            end
            S_PSCAN: begin
                w_mode = SC_PLACE;
                if (w_done) begin
                    if ((!w_fl.hit || w_fl.kind == PL_INSERT) && w_ffull) begin
                        n_res_st = ST_FULL;
                    end else begin
                        w_uop       = OP_SHL;
                        w_uidx      = r_uidx;
                        n_ucount    = r_ucount - 1'b1;
                        n_res_bytes = r_tsize;
                        n_res_st    = ST_OK;
                        w_fidx      = w_fl_h;
                        if (!w_fl.hit) begin
                            // append after the last entry
                            w_fop    = OP_WRITE;
                            w_fidx   = r_fcount[IW-1:0];
                            n_fcount = r_fcount + 1'b1;
                        end else begin
                            case (w_fl.kind)
                                PL_FRONT: begin
                                    w_fop        = OP_WRITE;
                                    w_fnew_start = r_key_addr;
                                    w_fnew_size  = w_fl.size + r_tsize;
                                end
                                PL_BACK: begin
                                    w_fop        = OP_WRITE;
                                    w_fnew_start = w_fl.start;
                                    w_fnew_size  = w_fl.size + r_tsize;
                                end
                                default: begin
                                    w_fop    = OP_SHR;
                                    n_fcount = r_fcount + 1'b1;
                                end
                            endcase
                        end
                    end
                end
            end
            S_JSCAN: begin
                w_mode = SC_JOIN;
                if (w_done && w_fl.hit) begin
                    w_fop        = OP_WRITE;
                    w_fidx       = w_fl_h;
                    w_fnew_start = w_fl.start;
                    w_fnew_size  = w_fl.size;
                    n_jidx       = w_fl_h;
                end
            end
            S_JSHIFT: begin
                // drop the entry that was folded into its left neighbor
                w_fop    = OP_SHL;
                w_fidx   = r_jidx + 1'b1;
                n_fcount = r_fcount - 1'b1;
            end
            S_DONE: begin
                if (!r_mvalid || m_axis_tready) begin
                    n_mvalid     = 1'b1;
                    n_mout_addr  = r_res_addr;
                    n_mout_bytes = r_res_bytes;
                    n_mout_st    = r_res_st;
                end
            end
            default: begin
            end
        endcase

        // register write rebuilds both tables
        if (w_cfg_hit) begin
            if (i_cfg_addr == CFG_HEAP_START) n_heap_start = i_cfg_wdata;
            else n_heap_len = i_cfg_wdata[SIZE_W-1:0];
            w_fop        = OP_WRITE;
            w_fidx       = '0;
            w_fnew_start = n_heap_start;
            w_fnew_size  = n_heap_len;
            n_fcount     = CW'(1);
            n_ucount     = '0;
        end

        // reset seeds the first free entry
        if (!i_rst_n) begin
            w_fop        = OP_WRITE;
            w_fidx       = '0;
            w_fnew_start = HEAP_START_RST;
            w_fnew_size  = HEAP_LENGTH_RST;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_heap_start <= HEAP_START_RST;
            r_heap_len   <= HEAP_LENGTH_RST;
            r_fcount     <= CW'(1);
            r_ucount     <= '0;
            r_mvalid     <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_heap_start <= n_heap_start;
            r_heap_len   <= n_heap_len;
            r_fcount     <= n_fcount;
            r_ucount     <= n_ucount;
            r_mvalid     <= n_mvalid;
            r_cnt        <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key_size   <= n_key_size;
        r_key_addr   <= n_key_addr;
        r_key_end    <= n_key_end;
        r_tsize      <= n_tsize;
        r_uidx       <= n_uidx;
        r_jidx       <= n_jidx;
        r_res_addr   <= n_res_addr;
        r_res_bytes  <= n_res_bytes;
        r_res_st     <= n_res_st;
        r_mout_addr  <= n_mout_addr;
        r_mout_bytes <= n_mout_bytes;
        r_mout_st    <= n_mout_st;
    end

    // rows of cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [ADDR_W-1:0] w_fls, w_frs, w_urs;
        logic [SIZE_W-1:0] w_flz, w_frz, w_urz;
        t_fcarry           w_fci;
        logic [IW-1:0]     w_fhi, w_fbi, w_uhi;
        t_ucarry           w_uci;

        if (g == 0) begin : g_first
            assign w_fls = '0;
            assign w_flz = '0;
            assign w_fci = '0;
            assign w_fhi = '0;
            assign w_fbi = '0;
            assign w_uci = '0;
            assign w_uhi = '0;
        end else begin : g_mid
            assign w_fls = w_fs[g-1];
            assign w_flz = w_fz[g-1];
            assign w_fci = w_fc[g-1];
            assign w_fhi = w_fh[g-1];
            assign w_fbi = w_fb[g-1];
            assign w_uci = w_uc[g-1];
            assign w_uhi = w_uh[g-1];
        end

        if (g == N - 1) begin : g_last
            assign w_frs = '0;
            assign w_frz = '0;
            assign w_urs = '0;
            assign w_urz = '0;
        end else begin : g_inner
            assign w_frs = w_fs[g+1];
            assign w_frz = w_fz[g+1];
            assign w_urs = w_us[g+1];
            assign w_urz = w_uz[g+1];
        end

        bfha_free_cell #(.IW(IW), .CW(CW)) u_free (
            .i_clk        (i_clk),
            .i_pos        (IW'(g)),
            .i_count      (r_fcount),
            .i_op         (w_fop),
            .i_idx        (w_fidx),
            .i_new_start  (w_fnew_start),
            .i_new_size   (w_fnew_size),
            .i_left_start (w_fls),
            .i_left_size  (w_flz),
            .i_right_start(w_frs),
            .i_right_size (w_frz),
            .o_start      (w_fs[g]),
            .o_size       (w_fz[g]),
            .i_mode       (w_mode),
            .i_key_size   (r_key_size),
            .i_key_addr   (r_key_addr),
            .i_key_end    (r_key_end),
            .i_carry      (w_fci),
            .i_hidx       (w_fhi),
            .i_bidx       (w_fbi),
            .o_carry      (w_fc[g]),
            .o_hidx       (w_fh[g]),
            .o_bidx       (w_fb[g])
        );

        bfha_used_cell #(.IW(IW), .CW(CW)) u_used (
            .i_clk        (i_clk),
            .i_pos        (IW'(g)),
            .i_count      (r_ucount),
            .i_op         (w_uop),
            .i_idx        (w_uidx),
            .i_new_start  (w_unew_start),
            .i_new_size   (w_unew_size),
            .i_right_start(w_urs),
            .i_right_size (w_urz),
            .o_start      (w_us[g]),
            .o_size       (w_uz[g]),
            .i_key_addr   (r_key_addr),
            .i_carry      (w_uci),
            .i_hidx       (w_uhi),
            .o_carry      (w_uc[g]),
            .o_hidx       (w_uh[g])
        );
    end

endmodule
`default_nettype wire
